FILE: hdl/tcp_option_list_parser_defines.svh
// assertion macros for the tcp option list parser checker
// expects clk and rst in the scope of each use
`ifndef TCP_OPTION_LIST_PARSER_DEFINES_SVH
`define TCP_OPTION_LIST_PARSER_DEFINES_SVH

// same-cycle implication
`define TOL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tol check failed");

// next-cycle implication
`define TOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tol check failed");

`endif

FILE: hdl/tol_pkg.sv
// shared types and constants for the tcp option list parser
// no dependencies
package tol_pkg;

  localparam int BYTE_W             = 8;
  localparam int AREA_W             = 6;
  localparam int IDX_W              = 5;
  localparam int MAX_AREA_BYTES_DEF = 40;
  localparam int FIFO_DEPTH         = 4;
  localparam int PTR_W              = $clog2(FIFO_DEPTH);
  localparam int MAX_DATA_LEN       = 38;
  localparam int MAX_OFFSET         = 39;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_KIND = 2'd1,
    MODE_LEN  = 2'd2,
    MODE_SKIP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RES_OPTION = 2'd0,
    RES_OK     = 2'd1,
    RES_BROKEN = 2'd2
  } res_type_t;

  typedef struct packed {
    logic [BYTE_W-1:0] opt_byte;
    logic              is_first;
    logic [AREA_W-1:0] area_length;
  } item_t;

  typedef struct packed {
    res_type_t         rtype;
    logic [BYTE_W-1:0] kind;
    logic [AREA_W-1:0] offset;
    logic [AREA_W-1:0] dlen;
    logic [IDX_W-1:0]  index;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } parse_out_t;

endpackage

FILE: hdl/tol_opt_if.sv
// input channel: one byte of the options area per transfer
// depends on tol_pkg
interface tol_opt_if;
  logic                      valid;
  logic                      ready;
  logic [tol_pkg::BYTE_W-1:0] opt_byte;
  logic                      is_first;
  logic [tol_pkg::AREA_W-1:0] area_length;

  modport source(output valid, output opt_byte, output is_first, output area_length,
                 input ready);
  modport sink(input valid, input opt_byte, input is_first, input area_length,
               output ready);
endinterface

FILE: hdl/tol_res_if.sv
// result channel: option records and area status
// depends on tol_pkg
interface tol_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_type;
  logic [tol_pkg::BYTE_W-1:0] option_kind;
  logic [tol_pkg::AREA_W-1:0] option_offset;
  logic [tol_pkg::AREA_W-1:0] opt_data_len;
  logic [tol_pkg::IDX_W-1:0]  entry_index;
  logic                      is_last;

  modport source(output valid, output result_type, output option_kind,
                 output option_offset, output opt_data_len, output entry_index,
                 output is_last, input ready);
  modport sink(input valid, input result_type, input option_kind,
               input option_offset, input opt_data_len, input entry_index,
               input is_last, output ready);
endinterface

FILE: hdl/tol_in_reg.sv
// input register stage for option bytes
// depends on tol_pkg and tol_opt_if
module tol_in_reg (
  input  logic           clk,
  input  logic           rst,
  tol_opt_if.sink        opt_chan,
  input  logic           advance,
  output logic           item_valid,
  output tol_pkg::item_t item
);

  assign opt_chan.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (opt_chan.ready) begin
      item_valid <= opt_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (opt_chan.valid && opt_chan.ready) begin
      item.opt_byte    <= opt_chan.opt_byte;
      item.is_first    <= opt_chan.is_first;
      item.area_length <= opt_chan.area_length;
    end
  end

endmodule

FILE: hdl/tol_parse.sv
// per-byte parse state and result generation
// depends on tol_pkg
module tol_parse #(
  parameter int MAX_AREA_BYTES = tol_pkg::MAX_AREA_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  tol_pkg::item_t      item,
  input  logic                advance,
  output tol_pkg::parse_out_t po
);

  localparam logic [tol_pkg::AREA_W-1:0] MAX_LEN = tol_pkg::AREA_W'(MAX_AREA_BYTES);
  localparam logic [tol_pkg::IDX_W-1:0]  CNT_MAX = '1;

  tol_pkg::mode_t              mode, mode_next, m0;
  logic [tol_pkg::AREA_W-1:0]  bytes_left, left_next, rem, left1, alen_c;
  logic [tol_pkg::AREA_W-1:0]  skip_left, skip_next, skip0, skip1;
  logic [tol_pkg::AREA_W-1:0]  byte_position, pos_next, pos0;
  logic [tol_pkg::BYTE_W-1:0]  pending_kind, kind_next, b, rem_p1;
  logic [tol_pkg::AREA_W-1:0]  pending_offset, offset_next, dlen;
  logic [tol_pkg::IDX_W-1:0]   entry_count, count_next, cnt0;
  logic                        start, zero_area;

  function automatic tol_pkg::result_t status_res(tol_pkg::res_type_t t,
                                                  logic [tol_pkg::IDX_W-1:0] cnt);
    tol_pkg::result_t r;
    r       = '0;
    r.rtype = t;
    r.index = cnt;
    r.last  = 1'b1;
    return r;
  endfunction

  assign b         = item.opt_byte;
  assign start     = item.is_first;
  assign zero_area = item.area_length == '0;
  assign alen_c    = (item.area_length > MAX_LEN) ? MAX_LEN : item.area_length;
  assign m0        = start ? (zero_area ? tol_pkg::MODE_IDLE : tol_pkg::MODE_KIND) : mode;
  assign rem       = start ? alen_c : bytes_left;
  assign skip0     = start ? '0 : skip_left;
  assign pos0      = start ? '0 : byte_position;
  assign cnt0      = start ? '0 : entry_count;
  assign left1     = rem - 1'b1;
  assign rem_p1    = {{(tol_pkg::BYTE_W - tol_pkg::AREA_W){1'b0}}, rem} + 1'b1;
  assign dlen      = tol_pkg::AREA_W'(b - 8'd2);
  assign skip1     = (skip0 != '0) ? skip0 - 1'b1 : '0;

  always_comb begin
    mode_next   = mode;
    left_next   = bytes_left;
    skip_next   = skip_left;
    pos_next    = byte_position;
    kind_next   = pending_kind;
    offset_next = pending_offset;
    count_next  = entry_count;
    po          = '0;
    if (item_valid) begin
      mode_next  = m0;
      left_next  = rem;
      skip_next  = skip0;
      pos_next   = pos0;
      count_next = cnt0;
      if (start && zero_area) begin
        kind_next   = '0;
        offset_next = '0;
      end
      if (m0 != tol_pkg::MODE_IDLE) begin
        if (rem == '0) begin
          mode_next = tol_pkg::MODE_IDLE;
        end else begin
          left_next = left1;
          pos_next  = pos0 + 1'b1;
          case (m0)
            tol_pkg::MODE_KIND: begin
              if (b == 8'd0 || (b == 8'd1 && left1 == '0)) begin
                po.valid0 = 1'b1;
                po.res0   = status_res(tol_pkg::RES_OK, cnt0);
                mode_next = tol_pkg::MODE_IDLE;
                left_next = '0;
                skip_next = '0;
              end else if (b == 8'd1) begin
                mode_next = tol_pkg::MODE_KIND;
              end else if (rem < 6'd2) begin
                po.valid0 = 1'b1;
                po.res0   = status_res(tol_pkg::RES_BROKEN, cnt0);
                mode_next = tol_pkg::MODE_IDLE;
                left_next = '0;
                skip_next = '0;
              end else begin
                kind_next   = b;
                offset_next = pos0;
                mode_next   = tol_pkg::MODE_LEN;
              end
            end
            tol_pkg::MODE_LEN: begin
              if (b < 8'd2 || b > rem_p1) begin
                po.valid0 = 1'b1;
                po.res0   = status_res(tol_pkg::RES_BROKEN, cnt0);
                mode_next = tol_pkg::MODE_IDLE;
                left_next = '0;
                skip_next = '0;
              end else begin
                po.valid0       = 1'b1;
                po.res0.rtype   = tol_pkg::RES_OPTION;
                po.res0.kind    = pending_kind;
                po.res0.offset  = pending_offset;
                po.res0.dlen    = dlen;
                po.res0.index   = cnt0;
                po.res0.last    = 1'b0;
                count_next      = (cnt0 != CNT_MAX) ? cnt0 + 1'b1 : cnt0;
                skip_next       = dlen;
                if (left1 == '0) begin
                  po.valid1 = 1'b1;
                  po.res1   = status_res(tol_pkg::RES_OK, count_next);
                  mode_next = tol_pkg::MODE_IDLE;
                  skip_next = '0;
                end else begin
                  mode_next = (dlen != '0) ? tol_pkg::MODE_SKIP : tol_pkg::MODE_KIND;
                end
              end
            end
            tol_pkg::MODE_SKIP: begin
              skip_next = skip1;
              if (left1 == '0) begin
                po.valid0 = 1'b1;
                po.res0   = status_res(tol_pkg::RES_OK, cnt0);
                mode_next = tol_pkg::MODE_IDLE;
                skip_next = '0;
              end else if (skip1 == '0) begin
                mode_next = tol_pkg::MODE_KIND;
              end
            end
            default: begin
              mode_next = tol_pkg::MODE_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= tol_pkg::MODE_IDLE;
      bytes_left     <= '0;
      skip_left      <= '0;
      byte_position  <= '0;
      pending_kind   <= '0;
      pending_offset <= '0;
      entry_count    <= '0;
    end else if (advance) begin
      mode           <= mode_next;
      bytes_left     <= left_next;
      skip_left      <= skip_next;
      byte_position  <= pos_next;
      pending_kind   <= kind_next;
      pending_offset <= offset_next;
      entry_count    <= count_next;
    end
  end

endmodule

FILE: hdl/tol_out_fifo.sv
// result queue: takes up to two results a cycle, hands out one while res_chan is ready
// depends on tol_pkg and tol_res_if
module tol_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tol_pkg::parse_out_t po,
  output logic                room,
  tol_res_if.source           res_chan
);

  tol_pkg::result_t            mem [tol_pkg::FIFO_DEPTH];
  logic [tol_pkg::PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [tol_pkg::PTR_W:0]     count;
  logic [tol_pkg::PTR_W:0]     n_push;
  logic                        pop;
  tol_pkg::result_t            head;

  assign n_push = push ? ((tol_pkg::PTR_W+1)'(po.valid0) + (tol_pkg::PTR_W+1)'(po.valid1))
                       : '0;
  assign pop    = res_chan.valid && res_chan.ready;
  assign room   = count <= (tol_pkg::PTR_W+1)'(tol_pkg::FIFO_DEPTH - 2);
  assign head   = mem[rd_ptr];

  assign res_chan.valid         = count != '0;
  assign res_chan.result_type   = head.rtype;
  assign res_chan.option_kind   = head.kind;
  assign res_chan.option_offset = head.offset;
  assign res_chan.opt_data_len  = head.dlen;
  assign res_chan.entry_index   = head.index;
  assign res_chan.is_last       = head.last;

  always_ff @(posedge clk) begin
    if (push && po.valid0) begin
      mem[wr_ptr] <= po.res0;
    end
    if (push && po.valid1) begin
      mem[wr_ptr + 1'b1] <= po.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[tol_pkg::PTR_W-1:0];
      rd_ptr <= rd_ptr + (tol_pkg::PTR_W)'(pop);
      count  <= count + n_push - (tol_pkg::PTR_W+1)'(pop);
    end
  end

endmodule

FILE: hdl/tcp_option_list_parser.sv
// tcp option list parser top level
// channel   | dir | payload
// opt_chan  | in  | opt_byte, is_first, area_length
// res_chan  | out | result_type, option_kind, option_offset, opt_data_len,
//           |     | entry_index, is_last
// one option byte is taken per cycle while the result queue has room; a byte's
// results enter the queue as the byte leaves the input register
// a byte gives at most two results (a record and the closing status); the
// four-entry result queue drains one per cycle while res_chan is ready, and
// input stalls while it holds more than two entries
// rst is synchronous and clears parse state and the queue
// depends on tol_pkg, tol_opt_if, tol_res_if, tol_in_reg, tol_parse, tol_out_fifo
module tcp_option_list_parser #(
  parameter int MAX_AREA_BYTES = tol_pkg::MAX_AREA_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tol_opt_if.sink   opt_chan,
  tol_res_if.source res_chan
);

  logic                item_valid;
  tol_pkg::item_t      item;
  tol_pkg::parse_out_t po;
  logic                room;
  logic                advance;

  assign advance = item_valid && room;

  tol_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .opt_chan   (opt_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tol_parse #(
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .po         (po)
  );

  tol_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (advance),
    .po       (po),
    .room     (room),
    .res_chan (res_chan)
  );

endmodule

FILE: hdl/tol_checker.sv
// port-level checks on the tcp option list parser results
// depends on tol_pkg and tcp_option_list_parser_defines.svh
`include "tcp_option_list_parser_defines.svh"

module tol_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       valid,
  input logic                       ready,
  input logic [1:0]                 result_type,
  input logic [tol_pkg::BYTE_W-1:0] option_kind,
  input logic [tol_pkg::AREA_W-1:0] option_offset,
  input logic [tol_pkg::AREA_W-1:0] opt_data_len,
  input logic [tol_pkg::IDX_W-1:0]  entry_index,
  input logic                       is_last
);

  logic        status_shape;
  logic        record_shape;
  logic [27:0] res_bits;

  assign status_shape = is_last && option_kind == '0 && option_offset == '0 &&
                        opt_data_len == '0;
  assign record_shape = !is_last &&
                        opt_data_len <= tol_pkg::AREA_W'(tol_pkg::MAX_DATA_LEN) &&
                        option_offset <= tol_pkg::AREA_W'(tol_pkg::MAX_OFFSET) &&
                        option_kind > 8'd1;
  assign res_bits     = {result_type, option_kind, option_offset, opt_data_len,
                         entry_index, is_last};

  `TOL_ASSERT_NOW(a_status_form, valid && result_type != tol_pkg::RES_OPTION, status_shape)
  `TOL_ASSERT_NOW(a_record_form, valid && result_type == tol_pkg::RES_OPTION, record_shape)
  `TOL_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(res_bits))
  `TOL_ASSERT_NOW(a_reset_empty, $past(rst), !valid)

endmodule

bind tcp_option_list_parser tol_checker u_tol_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (res_chan.valid),
  .ready         (res_chan.ready),
  .result_type   (res_chan.result_type),
  .option_kind   (res_chan.option_kind),
  .option_offset (res_chan.option_offset),
  .opt_data_len  (res_chan.opt_data_len),
  .entry_index   (res_chan.entry_index),
  .is_last       (res_chan.is_last)
);
